// File: src/kekm_pkg.sv
// kekm_pkg: shared constants, key codes and the decode word type for the
// keyboard event key map. No dependencies; imported by every module but kekm_ram.
`default_nettype none

package kekm_pkg;

    // sizes fixed by the field widths
    localparam int KEY_SLOTS      = 8;
    localparam int KEY_IDX_W      = 3;
    localparam int CHAR_W         = 9;
    localparam int ROW_BITS       = 32;
    localparam int BIT_W          = 5;
    localparam int CHAR_SLOTS_DEF = 512;
    localparam int DELAY_W        = 8;

    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 8'd20;

    // item kinds
    typedef enum logic [1:0] {
        ACT_EVENT = 2'd0,
        ACT_TAKE  = 2'd1,
        ACT_POLL  = 2'd2,
        ACT_NOP   = 2'd3
    } act_t;

    // whole event words that move the ctrl modifier
    localparam logic [15:0] CTRL_OFF_WORD = 16'hA503;
    localparam logic [15:0] CTRL_ON_WORD  = 16'hA502;

    // state byte
    localparam logic [7:0] ST_PRESS   = 8'h01;
    localparam logic [7:0] ST_RELEASE = 8'h03;

    // modifier range that is skipped
    localparam logic [7:0] MOD_LO = 8'hA1;
    localparam logic [7:0] MOD_HI = 8'hA5;

    // key codes
    localparam logic [7:0] ARROW_UP    = 8'hB5;
    localparam logic [7:0] ARROW_DOWN  = 8'hB6;
    localparam logic [7:0] ARROW_LEFT  = 8'hB4;
    localparam logic [7:0] ARROW_RIGHT = 8'hB7;
    localparam logic [7:0] BTN_SELECT  = 8'hB1;
    localparam logic [7:0] KEY_ENTER   = 8'h0A;
    localparam logic [7:0] KEY_CAPS    = 8'hC1;
    localparam logic [7:0] KEY_BRK_L   = 8'h5B;
    localparam logic [7:0] KEY_BRK_R   = 8'h5D;
    localparam logic [7:0] KEY_F1      = 8'h81;
    localparam logic [7:0] KEY_F2      = 8'h82;
    localparam logic [7:0] KEY_F3      = 8'h83;
    localparam logic [7:0] KEY_F4      = 8'h84;
    localparam logic [7:0] KEY_F5      = 8'h85;
    localparam logic [7:0] FKEY_OFS    = 8'h80;

    // character codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CTRL_OFS  = 8'h60;

    localparam logic [CHAR_W-1:0] CHAR_CR = 9'd13;

    // joystick bit positions
    localparam logic [KEY_IDX_W-1:0] J_UP     = 3'd0;
    localparam logic [KEY_IDX_W-1:0] J_DOWN   = 3'd1;
    localparam logic [KEY_IDX_W-1:0] J_LEFT   = 3'd2;
    localparam logic [KEY_IDX_W-1:0] J_RIGHT  = 3'd3;
    localparam logic [KEY_IDX_W-1:0] J_A      = 3'd4;
    localparam logic [KEY_IDX_W-1:0] J_B      = 3'd5;
    localparam logic [KEY_IDX_W-1:0] J_SELECT = 3'd6;
    localparam logic [KEY_IDX_W-1:0] J_START  = 3'd7;

    // what one event word does
    typedef struct packed {
        logic                 ctrl_held;
        logic                 set;
        logic                 clr;
        logic                 joy_hit;
        logic [KEY_IDX_W-1:0] joy_idx;
        logic                 char_hit;
        logic [CHAR_W-1:0]    char_idx;
        logic                 reboot;
    } dec_t;

endpackage

`default_nettype wire

// File: src/kekm_ram.sv
// kekm_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module kekm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/kekm_decode.sv
// kekm_decode: turns one event word and the ctrl flag into joystick and
// character map actions. Depends on kekm_pkg.
`default_nettype none

module kekm_decode (
    input  wire logic [15:0]    event_word,
    input  wire logic           ctrl_held,
    output kekm_pkg::dec_t      dec
);

    import kekm_pkg::*;

    logic [7:0] code;
    logic [7:0] mcode;
    logic       ctrl_word;
    logic       skip;

    function automatic logic is_char_key(input logic [7:0] c);
        logic r;
        r = (c == CH_SPACE) || (c == CH_BS)
            || ((c >= CH_0) && (c <= CH_9))
            || ((c >= CH_LA) && (c <= CH_LF))
            || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR)
            || (c == CH_SLASH) || (c == CH_EQ) || (c == CH_DOT);
        return r;
    endfunction

    always_comb
    begin
        code      = event_word[15:8];
        dec       = '0;
        ctrl_word = (event_word == CTRL_OFF_WORD) || (event_word == CTRL_ON_WORD);

        dec.ctrl_held = ctrl_held;
        if (event_word == CTRL_OFF_WORD)
        begin
            dec.ctrl_held = 1'b0;
        end
        else if (event_word == CTRL_ON_WORD)
        begin
            dec.ctrl_held = 1'b1;
        end

        dec.set = !ctrl_word && (event_word[7:0] == ST_PRESS);
        dec.clr = !ctrl_word && (event_word[7:0] == ST_RELEASE);

        // ctrl letters fold to control codes
        mcode = code;
        if (dec.ctrl_held && (code >= CH_LA) && (code <= CH_LZ))
        begin
            mcode = code - CTRL_OFS;
        end

        skip = (event_word == 16'h0000) || ((code >= MOD_LO) && (code <= MOD_HI));

        if (!skip)
        begin
            unique case (mcode)
                ARROW_UP:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_UP;
                end
                ARROW_DOWN:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_DOWN;
                end
                ARROW_LEFT:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_LEFT;
                end
                ARROW_RIGHT:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_RIGHT;
                end
                BTN_SELECT:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_SELECT;
                end
                KEY_ENTER:
                begin
                    dec.joy_hit  = 1'b1;
                    dec.joy_idx  = J_START;
                    dec.char_hit = 1'b1;
                    dec.char_idx = CHAR_CR;
                end
                KEY_BRK_L:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_B;
                end
                KEY_BRK_R:
                begin
                    dec.joy_hit = 1'b1;
                    dec.joy_idx = J_A;
                end
                KEY_F1, KEY_F2, KEY_F3, KEY_F4, KEY_F5:
                begin
                    // function keys sit just above the byte range
                    dec.char_hit = 1'b1;
                    dec.char_idx = {1'b1, mcode - FKEY_OFS};
                end
                KEY_CAPS:
                begin
                    dec.reboot = dec.ctrl_held;
                end
                default:
                begin
                    if (is_char_key(mcode))
                    begin
                        dec.char_hit = 1'b1;
                        dec.char_idx = {1'b0, mcode};
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/keyboard_event_key_map.sv
// keyboard_event_key_map: top level with the item sequencer, joystick and repeat
// state and the character flag memory. Depends on kekm_pkg, kekm_decode, kekm_ram.
//
// Decodes keyboard event words into eight joystick bits and a map of character
// flags, hands out the lowest pending character on a take-char word and runs a
// per-key auto-repeat countdown on a repeat-poll word. One word is in flight at a
// time: a key event or repeat poll runs an execute step and then a done step that
// loads the result, with a read-modify-write step of the flag memory between the
// two when it touches the character map; a take-char scans the flag memory from
// its first row, reading one 32-flag row per cycle through the single read port,
// until it finds a flag or has checked the last row. A result held by the receiver
// holds the block in its last step. After reset a clearing pass zeroes the flag
// memory row by row before the first word is taken; configuration writes are
// taken at any time.
`default_nettype none

module keyboard_event_key_map #(
    parameter int CHAR_SLOTS = kekm_pkg::CHAR_SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kekm_pkg::DELAY_W-1:0]    cfg_data,
    // input words
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      action,
    input  wire logic [15:0]                     event_word,
    input  wire logic [kekm_pkg::KEY_IDX_W-1:0]  key_index,
    // result words
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [kekm_pkg::KEY_SLOTS-1:0]       key_states,
    output logic                                 any_key,
    output logic [kekm_pkg::CHAR_W-1:0]          char_code,
    output logic                                 repeat_fire,
    output logic                                 reboot_request
);

    import kekm_pkg::*;

    localparam int ROWS  = (CHAR_SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_EV_MOD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg;
    act_t                   action_reg;
    logic [15:0]            word_reg;
    logic [KEY_IDX_W-1:0]   key_index_reg;
    logic [DELAY_W-1:0]     delay_reg;
    logic                   ctrl_held_reg;
    logic [KEY_SLOTS-1:0]   joy_reg;
    logic [DELAY_W-1:0]     cnt_reg [KEY_SLOTS];
    logic [ROW_W-1:0]       chk_row_reg;
    logic [ROW_W-1:0]       ev_row_reg;
    logic [BIT_W-1:0]       ev_bit_reg;
    logic                   ev_set_reg;
    logic [CHAR_W-1:0]      chr_reg;
    logic                   fire_reg;
    logic                   reboot_reg;
    logic                   out_valid_reg;
    logic [KEY_SLOTS-1:0]   key_states_reg;
    logic                   any_key_reg;
    logic [CHAR_W-1:0]      char_code_reg;
    logic                   repeat_fire_reg;
    logic                   reboot_request_reg;

    dec_t                   dec;
    logic                   ram_we;
    logic [ROW_W-1:0]       ram_waddr;
    logic [ROW_BITS-1:0]    ram_wdata;
    logic [ROW_W-1:0]       ram_raddr;
    logic [ROW_BITS-1:0]    ram_rdata;
    logic                   scan_hit;
    logic [BIT_W-1:0]       hit_bit;
    logic                   out_load;

    function automatic logic [BIT_W-1:0] low_bit(input logic [ROW_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    kekm_decode u_decode (
        .event_word (word_reg),
        .ctrl_held  (ctrl_held_reg),
        .dec        (dec)
    );

    kekm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS),
        .ADDR_W(ROW_W)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_hit = |ram_rdata;
    assign hit_bit  = low_bit(ram_rdata);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // flag memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_row_reg;
        ram_wdata = '0;
        ram_raddr = chk_row_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_EXEC:
            begin
                if (action_reg == ACT_TAKE)
                begin
                    ram_raddr = '0;
                end
                else
                begin
                    ram_raddr = ROW_W'(dec.char_idx >> BIT_W);
                end
            end
            S_EV_MOD:
            begin
                ram_we    = 1'b1;
                ram_waddr = ev_row_reg;
                if (ev_set_reg)
                begin
                    ram_wdata = ram_rdata | (ROW_BITS'(1) << ev_bit_reg);
                end
                else
                begin
                    ram_wdata = ram_rdata & ~(ROW_BITS'(1) << ev_bit_reg);
                end
            end
            S_SCAN:
            begin
                // next row is read while this one is checked
                ram_raddr = ROW_W'(chk_row_reg + ROW_W'(1));
                if (scan_hit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(ROW_BITS'(1) << hit_bit);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            action_reg         <= ACT_NOP;
            word_reg           <= '0;
            key_index_reg      <= '0;
            delay_reg          <= REPEAT_DELAY_RST;
            ctrl_held_reg      <= 1'b0;
            joy_reg            <= '0;
            cnt_reg            <= '{default: '0};
            chk_row_reg        <= '0;
            ev_row_reg         <= '0;
            ev_bit_reg         <= '0;
            ev_set_reg         <= 1'b0;
            chr_reg            <= '0;
            fire_reg           <= 1'b0;
            reboot_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            key_states_reg     <= '0;
            any_key_reg        <= 1'b0;
            char_code_reg      <= '0;
            repeat_fire_reg    <= 1'b0;
            reboot_request_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                delay_reg <= cfg_data;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    if (chk_row_reg == LAST_ROW)
                    begin
                        chk_row_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        chk_row_reg <= ROW_W'(chk_row_reg + ROW_W'(1));
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg    <= act_t'(action);
                        word_reg      <= event_word;
                        key_index_reg <= key_index;
                        state_reg     <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    chr_reg     <= '0;
                    chk_row_reg <= '0;
                    unique case (action_reg)
                        ACT_EVENT:
                        begin
                            ctrl_held_reg <= dec.ctrl_held;
                            reboot_reg    <= dec.reboot;
                            fire_reg      <= 1'b0;
                            if (dec.joy_hit && (dec.set || dec.clr))
                            begin
                                joy_reg[dec.joy_idx] <= dec.set;
                            end
                            ev_row_reg <= ROW_W'(dec.char_idx >> BIT_W);
                            ev_bit_reg <= dec.char_idx[BIT_W-1:0];
                            ev_set_reg <= dec.set;
                            if (dec.char_hit && (dec.set || dec.clr))
                            begin
                                state_reg <= S_EV_MOD;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        ACT_TAKE:
                        begin
                            fire_reg   <= 1'b0;
                            reboot_reg <= 1'b0;
                            state_reg  <= S_SCAN;
                        end
                        ACT_POLL:
                        begin
                            reboot_reg <= 1'b0;
                            state_reg  <= S_DONE;
                            if (joy_reg[key_index_reg])
                            begin
                                if (cnt_reg[key_index_reg] == '0)
                                begin
                                    cnt_reg[key_index_reg] <= delay_reg;
                                    fire_reg               <= 1'b1;
                                end
                                else
                                begin
                                    cnt_reg[key_index_reg] <=
                                        cnt_reg[key_index_reg] - DELAY_W'(1);
                                    fire_reg               <= 1'b0;
                                end
                            end
                            else
                            begin
                                cnt_reg[key_index_reg] <= '0;
                                fire_reg               <= 1'b0;
                            end
                        end
                        ACT_NOP:
                        begin
                            fire_reg   <= 1'b0;
                            reboot_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_EV_MOD:
                begin
                    state_reg <= S_DONE;
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        chr_reg   <= CHAR_W'({chk_row_reg, hit_bit});
                        state_reg <= S_DONE;
                    end
                    else if (chk_row_reg == LAST_ROW)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        chk_row_reg <= ROW_W'(chk_row_reg + ROW_W'(1));
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        key_states_reg     <= joy_reg;
                        any_key_reg        <= |joy_reg;
                        char_code_reg      <= chr_reg;
                        repeat_fire_reg    <= fire_reg;
                        reboot_request_reg <= reboot_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign key_states     = key_states_reg;
    assign any_key        = any_key_reg;
    assign char_code      = char_code_reg;
    assign repeat_fire    = repeat_fire_reg;
    assign reboot_request = reboot_request_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted word did not start execution");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("flag memory written while idle");

    a_fire_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && fire_reg) |-> (action_reg == ACT_POLL))
        else $error("repeat fire outside a repeat poll");

    a_char_take: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (chr_reg != '0)) |-> (action_reg == ACT_TAKE))
        else $error("character returned outside a take");

    a_reboot_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && reboot_reg) |-> ((action_reg == ACT_EVENT) && ctrl_held_reg))
        else $error("reboot without ctrl held on a key event");

endmodule

`default_nettype wire

// File: test/keyboard_event_key_map_tb.sv
// keyboard_event_key_map_tb: self-checking bench for the keyboard event key map.
// Needs kekm_pkg and keyboard_event_key_map; drives a directed table then random
// key sequences; checks each result against its table row or a behavioural predictor.
`timescale 1ns / 100ps

module keyboard_event_key_map_tb;

    import kekm_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 24;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int LONG_HOLDOFF    = 400;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 335;
    localparam int DIRECTED_ROWS   = 25;
    localparam int TIMEOUT_NS      = 5_000_000;

    // letters used by the directed table
    localparam logic [7:0] CH_LH = 8'h68;
    localparam logic [7:0] CH_LJ = 8'h6A;
    localparam logic [7:0] CH_LX = 8'h78;

    localparam logic [7:0] JOY_CODES [8] = '{ARROW_UP, ARROW_DOWN, ARROW_LEFT, ARROW_RIGHT,
                                             BTN_SELECT, KEY_ENTER, KEY_BRK_L, KEY_BRK_R};
    localparam logic [7:0] PUNCT_CODES [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                               CH_EQ, CH_DOT, CH_SPACE, CH_BS};

    typedef struct packed {
        act_t                 act;
        logic [15:0]          word;
        logic [KEY_IDX_W-1:0] kidx;
    } key_item_t;

    typedef struct packed {
        logic [KEY_SLOTS-1:0] states;
        logic                 any;
        logic [CHAR_W-1:0]    chr;
        logic                 fire;
        logic                 reboot;
    } key_map_result_t;

    typedef struct packed {
        key_item_t       item;
        logic            typed;
        key_map_result_t want;
    } directed_row_t;

    localparam key_map_result_t IDLE_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [DELAY_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           action;
    logic [15:0]          event_word;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [KEY_SLOTS-1:0] key_states;
    logic                 any_key;
    logic [CHAR_W-1:0]    char_code;
    logic                 repeat_fire;
    logic                 reboot_request;

    // predictor state
    logic                       ctrl_down;
    logic [KEY_SLOTS-1:0]       joy_held;
    logic [CHAR_SLOTS_DEF-1:0]  char_pending;
    logic [DELAY_W-1:0]         repeat_count [KEY_SLOTS];
    logic [DELAY_W-1:0]         repeat_delay_val;

    key_map_result_t pending_results [$];
    int mismatch_count    = 0;
    int send_free_left    = 0;
    int holdoff_requests  = 0;
    int holdoffs_done     = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{ACT_TAKE,  16'h0000, 3'd0}, 1'b1, IDLE_RESULT},
        '{'{ACT_NOP,   16'hFFFF, 3'd7}, 1'b1, IDLE_RESULT},
        '{'{ACT_EVENT, 16'h0000, 3'd7}, 1'b1, IDLE_RESULT},
        '{'{ACT_EVENT, {ARROW_UP, ST_PRESS}, 3'd0}, 1'b1, '{8'h01, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_EVENT, {ARROW_DOWN, ST_PRESS}, 3'd0}, 1'b1, '{8'h03, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_EVENT, {ARROW_RIGHT, ST_PRESS}, 3'd0}, 1'b1, '{8'h0B, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_EVENT, {KEY_BRK_R, ST_PRESS}, 3'd0}, 1'b1, '{8'h1B, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_EVENT, {KEY_BRK_L, ST_PRESS}, 3'd0}, 1'b1, '{8'h3B, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_EVENT, {BTN_SELECT, ST_PRESS}, 3'd0}, 1'b1, '{8'h7B, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_EVENT, {KEY_ENTER, ST_PRESS}, 3'd0}, 1'b1, '{8'hFB, 1'b1, 9'd0, 1'b0, 1'b0}},
        '{'{ACT_POLL,  16'h0000, J_START}, 1'b1, '{8'hFB, 1'b1, 9'd0, 1'b1, 1'b0}},
        '{'{ACT_POLL,  16'h0000, J_START}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {CH_LA, ST_PRESS}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {KEY_F5, ST_PRESS}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {ARROW_UP, 8'h02}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {CH_LX, ST_PRESS}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, CTRL_ON_WORD, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {CH_LH, ST_PRESS}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {CH_LJ, ST_RELEASE}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {KEY_CAPS, 8'h00}, 3'd0}, 1'b1, '{8'h7B, 1'b1, 9'd0, 1'b0, 1'b1}},
        '{'{ACT_EVENT, CTRL_OFF_WORD, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {KEY_CAPS, ST_PRESS}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_TAKE,  16'h0000, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_EVENT, {ARROW_UP, ST_RELEASE}, 3'd0}, 1'b0, IDLE_RESULT},
        '{'{ACT_POLL,  16'h0000, J_UP}, 1'b0, IDLE_RESULT}
    };

    keyboard_event_key_map DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .event_word     (event_word),
        .key_index      (key_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .key_states     (key_states),
        .any_key        (any_key),
        .char_code      (char_code),
        .repeat_fire    (repeat_fire),
        .reboot_request (reboot_request)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic next_flag(input logic cur, input logic press, input logic lift);
        return press ? 1'b1 : (lift ? 1'b0 : cur);
    endfunction

    function automatic logic is_char_code(input logic [7:0] code);
        return code == CH_SPACE || code == CH_BS
            || (code >= CH_0 && code <= CH_9) || (code >= CH_LA && code <= CH_LF)
            || code == CH_PLUS || code == CH_MINUS || code == CH_STAR
            || code == CH_SLASH || code == CH_EQ || code == CH_DOT;
    endfunction

    // advances the predictor by one word and gives the result it should produce
    task automatic compute_key_map_result(input key_item_t item, output key_map_result_t res);
        logic [7:0]        code;
        logic              press;
        logic              lift;
        logic [CHAR_W-1:0] slot;
        logic              found;
        int                i;
        res = '0;
        press = 1'b0;
        lift = 1'b0;
        found = 1'b0;
        code = item.word[15:8];
        case (item.act)
            ACT_EVENT:
            begin
                if (item.word != 16'h0000)
                begin
                    if (item.word == CTRL_OFF_WORD)
                        ctrl_down = 1'b0;
                    else if (item.word == CTRL_ON_WORD)
                        ctrl_down = 1'b1;
                    else if (item.word[7:0] == ST_PRESS)
                        press = 1'b1;
                    else if (item.word[7:0] == ST_RELEASE)
                        lift = 1'b1;
                    // modifier codes never reach the key decode
                    if (code < MOD_LO || code > MOD_HI)
                    begin
                        if (ctrl_down && code >= CH_LA && code <= CH_LZ)
                            code = code - CTRL_OFS;
                        case (code)
                            ARROW_UP:    joy_held[J_UP] = next_flag(joy_held[J_UP], press, lift);
                            ARROW_DOWN:  joy_held[J_DOWN] =
                                             next_flag(joy_held[J_DOWN], press, lift);
                            ARROW_LEFT:  joy_held[J_LEFT] =
                                             next_flag(joy_held[J_LEFT], press, lift);
                            ARROW_RIGHT: joy_held[J_RIGHT] =
                                             next_flag(joy_held[J_RIGHT], press, lift);
                            BTN_SELECT:  joy_held[J_SELECT] =
                                             next_flag(joy_held[J_SELECT], press, lift);
                            KEY_BRK_L:   joy_held[J_B] = next_flag(joy_held[J_B], press, lift);
                            KEY_BRK_R:   joy_held[J_A] = next_flag(joy_held[J_A], press, lift);
                            KEY_ENTER:
                            begin
                                char_pending[CHAR_CR] =
                                    next_flag(char_pending[CHAR_CR], press, lift);
                                joy_held[J_START] = next_flag(joy_held[J_START], press, lift);
                            end
                            KEY_F1, KEY_F2, KEY_F3, KEY_F4, KEY_F5:
                            begin
                                slot = 9'(code - FKEY_OFS) + 9'd256;
                                char_pending[slot] = next_flag(char_pending[slot], press, lift);
                            end
                            KEY_CAPS: res.reboot = ctrl_down;
                            default:
                            begin
                                if (is_char_code(code))
                                    char_pending[9'(code)] =
                                        next_flag(char_pending[9'(code)], press, lift);
                            end
                        endcase
                    end
                end
            end
            ACT_TAKE:
            begin
                for (i = 0; i < CHAR_SLOTS_DEF; i++)
                begin
                    if (!found && char_pending[i])
                    begin
                        found = 1'b1;
                        res.chr = 9'(i);
                        char_pending[i] = 1'b0;
                    end
                end
            end
            ACT_POLL:
            begin
                if (!joy_held[item.kidx])
                    repeat_count[item.kidx] = '0;
                else if (repeat_count[item.kidx] == '0)
                begin
                    repeat_count[item.kidx] = repeat_delay_val;
                    res.fire = 1'b1;
                end
                else
                    repeat_count[item.kidx] = repeat_count[item.kidx] - 8'd1;
            end
            default: ;
        endcase
        res.states = joy_held;
        res.any = |joy_held;
    endtask

    function automatic int next_gap();
        int pick;
        if (send_free_left > 0)
        begin
            send_free_left--;
            return 0;
        end
        pick = $urandom_range(99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(3, 1);
        if (pick < 94)
        begin
            send_free_left = $urandom_range(150, 40);
            return 0;
        end
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [7:0] pick_key_code();
        case ($urandom_range(9))
            0, 1, 2: return JOY_CODES[$urandom_range(7)];
            3:       return KEY_F1 + 8'($urandom_range(4));
            4:       return KEY_CAPS;
            5:       return CH_0 + 8'($urandom_range(9));
            6:       return CH_LA + 8'($urandom_range(25));
            7:       return PUNCT_CODES[$urandom_range(7)];
            8:       return MOD_LO + 8'($urandom_range(4));
            default: return 8'($urandom);
        endcase
    endfunction

    // key event words for meaningful keys mixed with ctrl, take, poll and nop words, with noise in unused fields
    task automatic pick_random_item(output key_item_t item);
        int         pick;
        logic [7:0] state_byte;
        item.act = ACT_EVENT;
        item.word = 16'($urandom);
        item.kidx = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            if ($urandom_range(9) == 0)
                state_byte = 8'($urandom);
            else
                state_byte = ($urandom_range(1) == 0) ? ST_PRESS : ST_RELEASE;
            item.word = {pick_key_code(), state_byte};
        end
        else if (pick < 55)
            item.word = ($urandom_range(1) == 0) ? CTRL_ON_WORD : CTRL_OFF_WORD;
        else if (pick < 70)
            item.act = ACT_TAKE;
        else if (pick < 92)
            item.act = ACT_POLL;
        else if (pick < 96)
            item.act = ACT_NOP;
    endtask

    // entered and left at a falling edge; valid stays up until the caller moves on
    task automatic offer_word(input key_item_t item, input logic use_typed,
                              input key_map_result_t typed_want);
        int              gap;
        key_map_result_t predicted;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action = item.act;
        event_word = item.word;
        key_index = item.kidx;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        compute_key_map_result(item, predicted);
        pending_results.push_back(use_typed ? typed_want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        in_valid = 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_repeat_delay(input logic [DELAY_W-1:0] value);
        cfg_data = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        repeat_delay_val = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        key_map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result word with none pending", 0, 0);
            else
            begin
                want = pending_results.pop_front();
                if (key_states !== want.states)
                    report_mismatch("key_states", key_states, want.states);
                if (any_key !== want.any)
                    report_mismatch("any_key", any_key, want.any);
                if (char_code !== want.chr)
                    report_mismatch("char_code", char_code, want.chr);
                if (repeat_fire !== want.fire)
                    report_mismatch("repeat_fire", repeat_fire, want.fire);
                if (reboot_request !== want.reboot)
                    report_mismatch("reboot_request", reboot_request, want.reboot);
            end
        end
    end

    // result side: short and long stalls, free-running stretches, one forced hold-off
    initial
    begin : result_sink
        int   stall_left;
        int   free_left;
        int   pick;
        logic ready_next;
        stall_left = 0;
        free_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_requests != holdoffs_done)
            begin
                holdoffs_done++;
                stall_left = LONG_HOLDOFF;
                free_left = 0;
            end
            if (stall_left > 0)
            begin
                ready_next = 1'b0;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                ready_next = 1'b1;
                free_left--;
            end
            else
            begin
                pick = $urandom_range(99);
                ready_next = 1'b1;
                if (pick >= 96)
                begin
                    ready_next = 1'b0;
                    stall_left = $urandom_range(40, 10);
                end
                else if (pick >= 90)
                    free_left = $urandom_range(200, 50);
                else if (pick >= 70)
                begin
                    ready_next = 1'b0;
                    stall_left = $urandom_range(2, 0);
                end
            end
            out_ready = ready_next;
        end
    end

    initial
    begin : run_limit
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int                 row;
        int                 phase;
        int                 n;
        key_item_t          item;
        logic [DELAY_W-1:0] delay;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_NOP;
        event_word = '0;
        key_index = '0;
        ctrl_down = 1'b0;
        joy_held = '0;
        char_pending = '0;
        for (n = 0; n < KEY_SLOTS; n++)
            repeat_count[n] = '0;
        repeat_delay_val = REPEAT_DELAY_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_word(directed_rows[row].item, directed_rows[row].typed,
                       directed_rows[row].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       delay = 8'd0;
                1:       delay = 8'd255;
                2:       delay = 8'd1;
                3:       delay = 8'd3;
                default: delay = 8'($urandom_range(255));
            endcase
            write_repeat_delay(delay);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long stall on the result side while words keep coming
                if (phase == 1 && n == 120)
                    holdoff_requests++;
                // sender goes quiet until the block has emptied
                if (phase == 2 && n == 170)
                    wait_for_results();
                pick_random_item(item);
                offer_word(item, 1'b0, IDLE_RESULT);
            end
        end

        wait_for_results();
        if (pending_results.size() != 0)
            report_mismatch("result words never delivered", pending_results.size(), 0);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
